>>> rtl/assert_macros.svh
// Assertion macros shared by the activation unit RTL.
// Standalone header; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset
`define ASSERT_PROP(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, cond, msg)
`endif

`endif

>>> rtl/afu_pkg.sv
// Package for the activation function unit: kind and register codes,
// fixed-point constants and the sigmoid half table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package afu_pkg;

    // Activation selected by the kind register
    typedef enum logic [1:0] {
        KIND_RELU    = 2'd0,
        KIND_LEAKY   = 2'd1,
        KIND_SIGMOID = 2'd2,
        KIND_TANH    = 2'd3
    } kind_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_ACTIVATION_KIND = 1'b0,
        CFG_LEAK_SLOPE      = 1'b1
    } cfg_reg_t;

    localparam int DATA_W    = 16;
    localparam int FRAC_W    = 8;
    localparam int PROD_W    = 2 * DATA_W;

    localparam kind_t               KIND_RESET       = KIND_RELU;
    localparam logic signed [15:0]  LEAK_SLOPE_RESET = 16'sd26;

    // Sigmoid table geometry: bins over [-8, 8) in Q8.8
    localparam int SIG_TABLE_DEPTH = 256;
    localparam int SIG_INDEX_W     = $clog2(SIG_TABLE_DEPTH);
    localparam int SIG_HALF_DEPTH  = SIG_TABLE_DEPTH / 2;
    localparam int SIG_HALF_W      = 7;
    localparam int SIG_SPAN_W      = 12;
    localparam int SIG_OUT_W       = 9;

    localparam logic [SIG_SPAN_W-1:0]  SIG_BIAS = 12'h800;
    localparam logic signed [15:0]     SIG_LO   = -16'sd2048;
    localparam logic signed [15:0]     SIG_HI   = 16'sd2048;
    localparam logic [SIG_OUT_W-1:0]   SIG_ONE  = 9'd256;
    localparam logic [SIG_OUT_W-1:0]   SIG_ZERO = 9'd0;

    // round(256 / (1 + e^|c|)) for bin centres |c| = (2j+1)/32, j = 0..127.
    // Negative-side bins read it directly; positive-side bins read 256 minus it.
    localparam logic [SIG_HALF_W-1:0] SIG_HALF [SIG_HALF_DEPTH] = '{
        7'd126, 7'd122, 7'd118, 7'd114, 7'd110, 7'd106, 7'd102, 7'd99,
        7'd95,  7'd91,  7'd87,  7'd84,  7'd80,  7'd77,  7'd74,  7'd70,
        7'd67,  7'd64,  7'd61,  7'd58,  7'd56,  7'd53,  7'd50,  7'd48,
        7'd46,  7'd43,  7'd41,  7'd39,  7'd37,  7'd35,  7'd33,  7'd31,
        7'd30,  7'd28,  7'd27,  7'd25,  7'd24,  7'd22,  7'd21,  7'd20,
        7'd19,  7'd18,  7'd17,  7'd16,  7'd15,  7'd14,  7'd13,  7'd13,
        7'd12,  7'd11,  7'd10,  7'd10,  7'd9,   7'd9,   7'd8,   7'd8,
        7'd7,   7'd7,   7'd6,   7'd6,   7'd6,   7'd5,   7'd5,   7'd5,
        7'd4,   7'd4,   7'd4,   7'd4,   7'd3,   7'd3,   7'd3,   7'd3,
        7'd3,   7'd3,   7'd2,   7'd2,   7'd2,   7'd2,   7'd2,   7'd2,
        7'd2,   7'd2,   7'd1,   7'd1,   7'd1,   7'd1,   7'd1,   7'd1,
        7'd1,   7'd1,   7'd1,   7'd1,   7'd1,   7'd1,   7'd1,   7'd1,
        7'd1,   7'd1,   7'd1,   7'd1,   7'd0,   7'd0,   7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0
    };

endpackage

`default_nettype wire

>>> rtl/activation_function_unit.sv
// Top level of the activation function unit: config registers, input and
// result registers around the activation datapath. Uses afu_pkg,
// afu_sigmoid_lut and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Elementwise activation on signed Q8.8 samples: ReLU, leaky ReLU, sigmoid
// (256-bin table over [-8, 8)) or tanh, chosen by the activation_kind
// register. One sample is taken per clock unless the result side stalls.
// Its result is offered from the result register: the sample is captured
// in an input register, passes through the activation logic (a 16x16
// multiply for leaky ReLU, one table read for sigmoid and tanh) and lands
// in the result register. Backpressure on the result side stops the input
// side only when both registers hold data. last_in travels alongside as
// last_out. The configuration port always accepts; write it while no
// sample is in flight.
module activation_function_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,

    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] sample,
    input  wire logic               last_in,

    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      result_sample,
    output logic                    last_out
);

    // Configuration registers
    afu_pkg::kind_t         activation_kind_reg;
    logic signed [15:0]     leak_slope_reg;

    // Input stage
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic signed [15:0]     s1_sample_reg;
    logic                   s1_last_reg;
    logic                   s1_ready;

    // Result stage
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic signed [15:0]     out_sample_reg;
    logic                   out_last_reg;

    // Datapath
    logic signed [afu_pkg::PROD_W-1:0]  leak_prod;
    logic signed [23:0]                 leak_floor;
    logic signed [15:0]                 leak_sat;
    logic signed [15:0]                 tanh_arg;
    logic signed [15:0]                 sig_arg;
    logic [afu_pkg::SIG_OUT_W-1:0]      sig_val;
    logic signed [15:0]                 act_value;
    logic                               x_pos;
    logic                               in_xfer;
    logic                               s1_xfer;

    assign cfg_ready = 1'b1;

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            activation_kind_reg <= afu_pkg::KIND_RESET;
            leak_slope_reg      <= afu_pkg::LEAK_SLOPE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                afu_pkg::CFG_ACTIVATION_KIND:
                begin
                    activation_kind_reg <= afu_pkg::kind_t'(cfg_data[1:0]);
                end
                afu_pkg::CFG_LEAK_SLOPE:
                begin
                    leak_slope_reg <= $signed(cfg_data);
                end
                default:
                begin
                    leak_slope_reg <= leak_slope_reg;
                end
            endcase
        end
    end

    // Handshake: each stage advances when the next one is free or draining
    assign s1_ready = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_ready;
    assign in_xfer  = in_valid && in_ready;
    assign s1_xfer  = s1_valid_reg && s1_ready;

    always_comb
    begin
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_ready)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_xfer)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_sample_reg <= sample;
            s1_last_reg   <= last_in;
        end
    end

    // Leaky branch: floor(slope * x / 256), clamped to 16 bits
    assign leak_prod  = leak_slope_reg * s1_sample_reg;
    assign leak_floor = leak_prod[afu_pkg::PROD_W-1:afu_pkg::FRAC_W];

    always_comb
    begin
        if (leak_floor[23:15] == {9{leak_floor[23]}})
        begin
            leak_sat = leak_floor[15:0];
        end
        else if (leak_floor[23])
        begin
            leak_sat = 16'sh8000;
        end
        else
        begin
            leak_sat = 16'sh7fff;
        end
    end

    // Tanh argument: 2x, clamped to 16 bits
    always_comb
    begin
        if (s1_sample_reg[15] != s1_sample_reg[14])
        begin
            tanh_arg = s1_sample_reg[15] ? 16'sh8000 : 16'sh7fff;
        end
        else
        begin
            tanh_arg = {s1_sample_reg[14:0], 1'b0};
        end
    end

    // One table read serves both sigmoid and tanh
    assign sig_arg = (activation_kind_reg == afu_pkg::KIND_TANH) ? tanh_arg : s1_sample_reg;

    afu_sigmoid_lut u_sigmoid_lut (
        .arg (sig_arg),
        .sig (sig_val)
    );

    assign x_pos = !s1_sample_reg[15] && (s1_sample_reg != 16'sd0);

    // Select the activation
    always_comb
    begin
        case (activation_kind_reg)
            afu_pkg::KIND_RELU:
            begin
                act_value = x_pos ? s1_sample_reg : 16'sd0;
            end
            afu_pkg::KIND_LEAKY:
            begin
                act_value = x_pos ? s1_sample_reg : leak_sat;
            end
            afu_pkg::KIND_SIGMOID:
            begin
                act_value = $signed({7'b0, sig_val});
            end
            afu_pkg::KIND_TANH:
            begin
                act_value = $signed({6'b0, sig_val, 1'b0}) - 16'sd256;
            end
            default:
            begin
                act_value = 16'sd0;
            end
        endcase
    end

    // Load the result register when the input stage advances
    always_ff @(posedge clk)
    begin
        if (s1_xfer)
        begin
            out_sample_reg <= act_value;
            out_last_reg   <= s1_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_sample = out_sample_reg;
    assign last_out      = out_last_reg;

    // Checks
    `ASSERT_NEVER(a_stall_blocks_input, clk, rst_n,
        s1_valid_reg && out_valid_reg && !out_ready && in_ready,
        "input taken while both stages are full and stalled")
    `ASSERT_PROP(a_input_lands, clk, rst_n, in_xfer |=> s1_valid_reg,
        "input transfer did not reach the input stage")
    `ASSERT_PROP(a_stage_advances, clk, rst_n, s1_xfer |=> out_valid_reg,
        "input stage advance did not fill the result register")
    `ASSERT_PROP(a_sigmoid_range, clk, rst_n,
        (s1_valid_reg && activation_kind_reg == afu_pkg::KIND_SIGMOID)
            |-> (!act_value[15] && act_value[14:0] <= 15'd256),
        "sigmoid value outside 0..1")
    `ASSERT_PROP(a_relu_nonneg, clk, rst_n,
        (s1_valid_reg && activation_kind_reg == afu_pkg::KIND_RELU) |-> !act_value[15],
        "relu value negative")

endmodule

`default_nettype wire

>>> rtl/afu_sigmoid_lut.sv
// Sigmoid lookup: Q8.8 argument to unsigned Q1.8 sigmoid in 0..256, combinational.
// Depends on afu_pkg for the half table and range constants.
`timescale 1ns / 1ps
`default_nettype none

module afu_sigmoid_lut (
    input  wire logic signed [15:0]                 arg,
    output logic             [afu_pkg::SIG_OUT_W-1:0] sig
);

    logic [afu_pkg::SIG_SPAN_W-1:0]   offset;
    logic [afu_pkg::SIG_INDEX_W-1:0]  bin;
    logic [afu_pkg::SIG_INDEX_W-2:0]  half_idx;
    logic [afu_pkg::SIG_HALF_W-1:0]   half_val;
    logic                             below;
    logic                             above;

    // Shift the range [-8, 8) up to [0, 16) and keep the top bits as the bin
    assign offset = arg[afu_pkg::SIG_SPAN_W-1:0] ^ afu_pkg::SIG_BIAS;
    assign bin    = offset[afu_pkg::SIG_SPAN_W-1 -: afu_pkg::SIG_INDEX_W];

    // Fold the bin onto the half table by distance from the centre
    assign half_idx = bin[afu_pkg::SIG_INDEX_W-1] ? bin[afu_pkg::SIG_INDEX_W-2:0]
                                                  : ~bin[afu_pkg::SIG_INDEX_W-2:0];
    assign half_val = afu_pkg::SIG_HALF[half_idx];

    assign below = (arg < afu_pkg::SIG_LO);
    assign above = (arg >= afu_pkg::SIG_HI);

    // Clamp outside the table span, mirror on the positive side
    always_comb
    begin
        if (below)
        begin
            sig = afu_pkg::SIG_ZERO;
        end
        else if (above)
        begin
            sig = afu_pkg::SIG_ONE;
        end
        else if (bin[afu_pkg::SIG_INDEX_W-1])
        begin
            sig = afu_pkg::SIG_ONE - {2'b00, half_val};
        end
        else
        begin
            sig = {2'b00, half_val};
        end
    end

endmodule

`default_nettype wire
